// ===== hdl/json_key_value_extractor_assert.svh =====
// Assertion macros shared by the key/value extractor modules
`ifndef JSON_KEY_VALUE_EXTRACTOR_ASSERT_SVH
`define JSON_KEY_VALUE_EXTRACTOR_ASSERT_SVH

// Hold an invariant on every clock edge outside reset.
`define JKVE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// Require a consequence in the same cycle as its cause.
`define JKVE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Require a consequence in the cycle after its cause.
`define JKVE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== hdl/jkve_pkg.sv =====
// Types, constants and helper functions for the JSON key/value extractor
package jkve_pkg;

  localparam int KEY_MAX    = 32;
  localparam int NEST_BITS  = 16;
  localparam int WIN        = KEY_MAX + 2;
  localparam int KEY_CHARS  = 32;
  localparam int KEY_WORDS  = KEY_CHARS / 8;
  localparam int KC_W       = $clog2(KEY_CHARS);
  localparam int IDX_W      = $clog2(WIN);
  localparam int KLEN_W     = 6;
  localparam int CMP_W      = ((IDX_W > KLEN_W) ? IDX_W : KLEN_W) + 1;
  localparam int CAP_W      = 16;
  localparam int CNT_W      = 16;
  localparam int STAT_W     = 2;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_AFTER_KEY,
    PH_BEFORE_VALUE,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SCALAR,
    KIND_STRING,
    KIND_BRACE,
    KIND_BRACKET
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND,
    ST_NOT_FOUND,
    ST_NOT_STRING
  } status_t;

  typedef enum logic [2:0] {
    REG_KEY_A,
    REG_KEY_B,
    REG_KEY_C,
    REG_KEY_D,
    REG_KEY_LEN,
    REG_CAPACITY,
    REG_MODE
  } reg_idx_t;

  typedef logic [KEY_CHARS-1:0][7:0] key_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             last;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0] byte_count;
  } item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
  endfunction

  function automatic logic is_delim(input logic [7:0] ch);
    return (ch == CH_COMMA) || (ch == CH_RBRACE) || (ch == CH_RBRACK) || is_ws(ch);
  endfunction

endpackage

// ===== hdl/json_key_value_extractor.sv =====
// JSON key/value extractor: finds a quoted key and streams out its value
//
// Usage: text enters one byte per transfer on the in_ channel (in_text_byte,
// in_end_of_text). A zero byte or in_end_of_text closes the document. Each
// byte yields zero, one or two result items on the out_ channel: value bytes
// with out_last low, then one status item (out_last high, out_status,
// out_byte_count) that closes the run. Program the key, its length, the
// output capacity and the mode over the APB port while no run is pending.
// The items a byte yields are held in the result buffer and offered in order.
// Throughput: one text byte per cycle while in_ready is high, set by the
// row of window cells that shifts and compares once per byte and by the
// single-step state update. A four-entry result buffer parts the two
// channels; in_ready drops only while fewer than two entries are free, so
// a stalled receiver holds off text once three items wait, and no item is
// ever lost.
// Reset clears the window, the run state and the buffer, and loads the
// registers with their defaults (capacity 64, raw mode, empty key). End of
// text rearms the run state but keeps the registers.
`include "json_key_value_extractor_assert.svh"
module json_key_value_extractor (
  input  logic                          clk,
  input  logic                          rst_n,
  // text channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_end_of_text,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  output logic [jkve_pkg::STAT_W-1:0]   out_status,
  output logic [jkve_pkg::CNT_W-1:0]    out_byte_count,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jkve_pkg::ADDR_W-1:0]   paddr,
  input  logic [jkve_pkg::DATA_W-1:0]   pwdata,
  output logic [jkve_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import jkve_pkg::*;

  // ---------------------------------------------------------------- config
  logic [KEY_WORDS-1:0][DATA_W-1:0] key_r;
  logic [KEY_WORDS-1:0][DATA_W-1:0] key_nxt;
  logic [KLEN_W-1:0]                klen_r;
  logic [KLEN_W-1:0]                klen_nxt;
  logic [CAP_W-1:0]                 cap_r;
  logic [CAP_W-1:0]                 cap_nxt;
  logic                             mode_r;
  logic                             mode_nxt;
  logic                             cfg_wr;
  reg_idx_t                         reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_comb begin
    key_nxt  = key_r;
    klen_nxt = klen_r;
    cap_nxt  = cap_r;
    mode_nxt = mode_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_KEY_A:    key_nxt[0] = pwdata;
        REG_KEY_B:    key_nxt[1] = pwdata;
        REG_KEY_C:    key_nxt[2] = pwdata;
        REG_KEY_D:    key_nxt[3] = pwdata;
        REG_KEY_LEN:  klen_nxt   = pwdata[KLEN_W-1:0];
        REG_CAPACITY: cap_nxt    = pwdata[CAP_W-1:0];
        REG_MODE:     mode_nxt   = pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_A:    prdata = key_r[0];
      REG_KEY_B:    prdata = key_r[1];
      REG_KEY_C:    prdata = key_r[2];
      REG_KEY_D:    prdata = key_r[3];
      REG_KEY_LEN:  prdata = DATA_W'(klen_r);
      REG_CAPACITY: prdata = DATA_W'(cap_r);
      REG_MODE:     prdata = DATA_W'(mode_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      klen_r <= '0;
      cap_r  <= CAP_RESET;
      mode_r <= 1'b0;
    end else begin
      key_r  <= key_nxt;
      klen_r <= klen_nxt;
      cap_r  <= cap_nxt;
      mode_r <= mode_nxt;
    end
  end

  // ---------------------------------------------------------------- window
  logic            in_fire;
  logic            eot;
  logic [7:0]      b;
  cell_ctl_t       cell_ctl;
  logic [7:0]      win_byte [WIN];
  logic [WIN-1:0]  cell_ok;
  logic            win_match;

  assign in_fire = in_valid && in_ready;
  assign b       = in_text_byte;
  // A zero byte ends the text just as the flag does.
  assign eot     = in_end_of_text || (in_text_byte == CH_NUL);

  // Shift every real byte in; clear the whole row when the text ends.
  assign cell_ctl.shift = in_fire && !eot;
  assign cell_ctl.clear = in_fire && eot;

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    logic [7:0] feed;
    if (j == 0) begin : g_head
      assign feed = b;
    end else begin : g_body
      assign feed = win_byte[j-1];
    end
    jkve_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .cell_idx  (IDX_W'(j)),
      .key_len   (klen_r),
      .key_chars (key_t'(key_r)),
      .byte_in   (feed),
      .byte_out  (win_byte[j]),
      .char_ok   (cell_ok[j])
    );
  end

  // A key longer than the window never matches.
  assign win_match = (klen_r <= KLEN_W'(KEY_MAX)) && (&cell_ok);

  // ------------------------------------------------------------ run state
  phase_t           phase_r;
  phase_t           phase_nxt;
  kind_t            kind_r;
  kind_t            kind_nxt;
  logic [NEST_BITS-1:0] depth_r;
  logic [NEST_BITS-1:0] depth_nxt;
  logic [NEST_BITS-1:0] depth_dec;
  logic             ins_r;
  logic             ins_nxt;
  logic             esc_r;
  logic             esc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_new;
  logic [CAP_W-1:0] limit;
  logic [7:0]       open_ch;
  logic [7:0]       close_ch;

  logic             emit_req;
  logic [7:0]       emit_ch;
  logic             close_req;
  status_t          close_st;
  logic             cnt_zero;
  logic             lim_hit;
  logic             closing;
  item_t            stat_item;
  item_t            data_item;
  item_t            item_a;
  item_t            item_b;
  logic [1:0]       push_n;

  // Capacity zero behaves as capacity one: no value bytes at all.
  assign limit     = (cap_r == '0) ? '0 : cap_r - CAP_W'(1);
  assign open_ch   = (kind_r == KIND_BRACE) ? CH_LBRACE : CH_LBRACK;
  assign close_ch  = (kind_r == KIND_BRACE) ? CH_RBRACE : CH_RBRACK;
  assign depth_dec = (depth_r != '0) ? depth_r - NEST_BITS'(1) : depth_r;

  // Decide what this byte does: whether it emits a value byte, and whether
  // it closes the run. An emit that reaches the byte limit closes the run
  // itself, with status FOUND, and a close on the same byte adds no item.
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    depth_nxt = depth_r;
    ins_nxt   = ins_r;
    esc_nxt   = esc_r;
    emit_req  = 1'b0;
    emit_ch   = b;
    close_req = 1'b0;
    close_st  = ST_FOUND;
    cnt_zero  = 1'b0;
    if (eot) begin
      case (phase_r)
        PH_SEARCH, PH_AFTER_KEY: begin
          close_req = 1'b1;
          close_st  = ST_NOT_FOUND;
        end
        PH_BEFORE_VALUE: begin
          close_req = 1'b1;
          cnt_zero  = 1'b1;
          close_st  = mode_r ? ST_NOT_STRING : ST_FOUND;
        end
        PH_VALUE: begin
          // A dangling backslash in string mode goes out as itself.
          emit_req  = mode_r && esc_r;
          emit_ch   = CH_BSLASH;
          close_req = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (phase_r)
        PH_SEARCH: begin
          if (win_match) begin
            phase_nxt = PH_AFTER_KEY;
          end
        end
        PH_AFTER_KEY: begin
          if (!is_ws(b)) begin
            if (b == CH_COLON) begin
              phase_nxt = PH_BEFORE_VALUE;
            end else begin
              // An overlapping occurrence may end on this very byte.
              phase_nxt = win_match ? PH_AFTER_KEY : PH_SEARCH;
            end
          end
        end
        PH_BEFORE_VALUE: begin
          if (!is_ws(b)) begin
            cnt_zero  = 1'b1;
            ins_nxt   = 1'b0;
            esc_nxt   = 1'b0;
            depth_nxt = '0;
            phase_nxt = PH_VALUE;
            if (mode_r) begin
              if (b != CH_QUOTE) begin
                close_req = 1'b1;
                close_st  = ST_NOT_STRING;
              end else if (limit == '0) begin
                close_req = 1'b1;
              end else begin
                kind_nxt = KIND_STRING;
              end
            end else if (limit == '0) begin
              close_req = 1'b1;
            end else if (b == CH_QUOTE) begin
              kind_nxt = KIND_STRING;
              emit_req = 1'b1;
            end else if ((b == CH_LBRACE) || (b == CH_LBRACK)) begin
              kind_nxt  = (b == CH_LBRACE) ? KIND_BRACE : KIND_BRACKET;
              depth_nxt = NEST_BITS'(1);
              emit_req  = 1'b1;
            end else begin
              kind_nxt = KIND_SCALAR;
              if (is_delim(b)) begin
                close_req = 1'b1;
              end else begin
                emit_req = 1'b1;
              end
            end
          end
        end
        PH_VALUE: begin
          if (mode_r) begin
            // String contents: drop quotes and escape backslashes.
            if (esc_r) begin
              esc_nxt  = 1'b0;
              emit_req = 1'b1;
            end else if (b == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end else if (b == CH_QUOTE) begin
              close_req = 1'b1;
            end else begin
              emit_req = 1'b1;
            end
          end else if (kind_r == KIND_SCALAR) begin
            if (is_delim(b)) begin
              close_req = 1'b1;
            end else begin
              emit_req = 1'b1;
            end
          end else if ((kind_r == KIND_STRING) || ins_r) begin
            emit_req = 1'b1;
            if (esc_r) begin
              esc_nxt = 1'b0;
            end else if (b == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end else if (b == CH_QUOTE) begin
              if (kind_r == KIND_STRING) begin
                close_req = 1'b1;
              end else begin
                ins_nxt = 1'b0;
              end
            end
          end else begin
            // Group body: track depth on the group's own bracket pair.
            emit_req = 1'b1;
            if (b == CH_QUOTE) begin
              ins_nxt = 1'b1;
            end else if (b == open_ch) begin
              if (depth_r != '1) begin
                depth_nxt = depth_r + NEST_BITS'(1);
              end
            end else if (b == close_ch) begin
              depth_nxt = depth_dec;
              if (depth_dec == '0) begin
                close_req = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Pack the items and settle the count and the phase.
  always_comb begin
    cnt_base = cnt_zero ? '0 : cnt_r;
    cnt_new  = cnt_base + CNT_W'(emit_req);
    lim_hit  = emit_req && (cnt_new >= limit);
    closing  = lim_hit || close_req;

    data_item.out_byte   = emit_ch;
    data_item.last       = 1'b0;
    data_item.status     = ST_FOUND;
    data_item.byte_count = '0;

    stat_item.out_byte   = CH_NUL;
    stat_item.last       = 1'b1;
    stat_item.status     = lim_hit ? ST_FOUND : close_st;
    stat_item.byte_count = cnt_new;

    item_a = emit_req ? data_item : stat_item;
    item_b = stat_item;
    push_n = in_fire ? (2'(emit_req) + 2'(closing)) : 2'd0;
  end

  phase_t           phase_fin;
  kind_t            kind_fin;
  logic [NEST_BITS-1:0] depth_fin;
  logic             ins_fin;
  logic             esc_fin;
  logic [CNT_W-1:0] cnt_fin;

  // End of text rearms everything; otherwise a close parks the run in DONE.
  always_comb begin
    phase_fin = closing ? PH_DONE : phase_nxt;
    kind_fin  = kind_nxt;
    depth_fin = depth_nxt;
    ins_fin   = ins_nxt;
    esc_fin   = esc_nxt;
    cnt_fin   = cnt_new;
    if (eot) begin
      phase_fin = PH_SEARCH;
      kind_fin  = KIND_SCALAR;
      depth_fin = '0;
      ins_fin   = 1'b0;
      esc_fin   = 1'b0;
      cnt_fin   = '0;
    end
    cnt_nxt = cnt_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      kind_r  <= KIND_SCALAR;
      depth_r <= '0;
      ins_r   <= 1'b0;
      esc_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_fin;
      kind_r  <= kind_fin;
      depth_r <= depth_fin;
      ins_r   <= ins_fin;
      esc_r   <= esc_fin;
      cnt_r   <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  item_t head;

  jkve_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_a     (item_a),
    .push_b     (item_b),
    .pop_ready  (out_ready),
    .head       (head),
    .head_valid (out_valid),
    .room       (in_ready)
  );

  assign out_byte       = head.out_byte;
  assign out_last       = head.last;
  assign out_status     = head.status;
  assign out_byte_count = head.byte_count;

  `JKVE_ASSERT_IMPLY(a_done_silent, in_fire && !eot && (phase_r == PH_DONE), push_n == 2'd0)
  `JKVE_ASSERT_IMPLY(a_pair_order, push_n == 2'd2, !item_a.last && item_b.last)
  `JKVE_ASSERT_NEXT(a_end_rearms, in_fire && eot, (phase_r == PH_SEARCH) && (cnt_r == '0))

endmodule

// ===== hdl/jkve_cell.sv =====
// One window cell: holds a text byte, shifts it on, checks the incoming byte
module jkve_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jkve_pkg::cell_ctl_t          ctl,
  input  logic [jkve_pkg::IDX_W-1:0]   cell_idx,
  input  logic [jkve_pkg::KLEN_W-1:0]  key_len,
  input  jkve_pkg::key_t               key_chars,
  input  logic [7:0]                   byte_in,
  output logic [7:0]                   byte_out,
  output logic                         char_ok
);
  import jkve_pkg::*;

  logic [7:0]       byte_r;
  logic [7:0]       byte_nxt;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] kidx;
  logic [7:0]       want_ch;

  // The byte entering this cell is the one the match sees after the shift.
  always_comb begin
    pos     = CMP_W'(cell_idx);
    len     = CMP_W'(key_len);
    kidx    = len - pos;
    want_ch = CH_NUL;
    if (kidx < CMP_W'(KEY_CHARS)) begin
      want_ch = key_chars[kidx[KC_W-1:0]];
    end
    if ((pos == '0) || (pos == len + CMP_W'(1))) begin
      char_ok = (byte_in == CH_QUOTE);
    end else if (pos <= len) begin
      char_ok = (byte_in == want_ch);
    end else begin
      char_ok = 1'b1;
    end
  end

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = CH_NUL;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= CH_NUL;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule

// ===== hdl/jkve_out_fifo.sv =====
// Result buffer: takes up to two items a cycle, hands one on per transfer
`include "json_key_value_extractor_assert.svh"
module jkve_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_n,
  input  jkve_pkg::item_t push_a,
  input  jkve_pkg::item_t push_b,
  input  logic            pop_ready,
  output jkve_pkg::item_t head,
  output logic            head_valid,
  output logic            room
);
  import jkve_pkg::*;

  item_t                mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r;
  logic [OUT_PTR_W-1:0] wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r;
  logic [OUT_PTR_W-1:0] rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] count_r;
  logic [OUT_CNT_W-1:0] count_nxt;
  logic                 pop;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && pop_ready;
  // Leave space for the worst case of two items from one text byte.
  assign room       = (count_r <= OUT_CNT_W'(OUT_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
    count_nxt  = count_r + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + OUT_PTR_W'(1)] <= push_b;
    end
  end

  `JKVE_ASSERT_ALWAYS(a_fifo_bound, count_r <= OUT_CNT_W'(OUT_DEPTH))
  `JKVE_ASSERT_IMPLY(a_fifo_room, push_n != 2'd0, room)
  `JKVE_ASSERT_NEXT(a_fifo_drain, (push_n == 2'd0) && pop, count_r == $past(count_r) - OUT_CNT_W'(1))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the JSON key/value extractor: directed and random documents against a byte model
module testbench;
  import jkve_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off, enough to fill the result buffer
  localparam int STALL_LIMIT    = 2000;  // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES  = 8;     // quiet time after the last result before touching registers

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [7:0]          in_text_byte   = 8'h00;
  logic                in_end_of_text = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [7:0]          out_byte;
  logic                out_last;
  logic [STAT_W-1:0]   out_status;
  logic [CNT_W-1:0]    out_byte_count;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ADDR_W-1:0]   paddr          = '0;
  logic [DATA_W-1:0]   pwdata         = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  always #6 clk = ~clk;

  json_key_value_extractor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_byte_count (out_byte_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ---------------------------------------------------------------------------
  // Extractor model: register copy, scan state and the queue of results due
  // ---------------------------------------------------------------------------
  logic [63:0]          key_word [KEY_WORDS];
  logic [KLEN_W-1:0]    key_len;
  logic [CAP_W-1:0]     capacity;
  logic                 string_mode;

  logic [7:0]           window [WIN];     // window[0] is the newest text byte
  phase_t               ph;
  kind_t                kind;
  logic [NEST_BITS-1:0] depth;
  logic                 in_str;
  logic                 esc;
  logic [CNT_W-1:0]     emitted;

  item_t                results_due [$];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  bit  no_gaps        = 1'b0;   // suppress idling on both sides
  bit  sink_pause     = 1'b0;   // request one long receiver hold-off

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic ends_scalar(input logic [7:0] b);
    return b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACK || is_blank(b);
  endfunction

  // Capacity counts the terminator slot, so one byte fewer can be emitted;
  // zero behaves like one.
  function automatic logic [CNT_W-1:0] value_limit();
    return (capacity == 0) ? '0 : capacity - 1'b1;
  endfunction

  // Quote, key characters, quote, ending at the newest byte.
  function automatic logic key_at_window();
    int plen;
    int i;
    if (key_len > KEY_MAX) return 1'b0;
    plen = int'(key_len) + 2;
    if (window[0] != CH_QUOTE || window[plen-1] != CH_QUOTE) return 1'b0;
    for (i = 0; i < int'(key_len); i++)
      if (window[plen-2-i] != key_word[i/8][(i%8)*8 +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic rearm_model();
    foreach (window[i]) window[i] = 8'h00;
    ph      = PH_SEARCH;
    kind    = KIND_SCALAR;
    depth   = '0;
    in_str  = 1'b0;
    esc     = 1'b0;
    emitted = '0;
  endtask

  task automatic reset_model();
    foreach (key_word[i]) key_word[i] = '0;
    key_len     = '0;
    capacity    = CAP_RESET;
    string_mode = 1'b0;
    rearm_model();
  endtask

  task automatic note_result(input logic [7:0] b, input logic last, input status_t st,
                             input logic [CNT_W-1:0] cnt);
    item_t r;
    r.out_byte   = b;
    r.last       = last;
    r.status     = st;
    r.byte_count = cnt;
    results_due.push_back(r);
  endtask

  task automatic close_value(input status_t st);
    note_result(8'h00, 1'b1, st, emitted);
    ph = PH_DONE;
  endtask

  task automatic emit_value_byte(input logic [7:0] b);
    note_result(b, 1'b0, ST_FOUND, '0);
    emitted++;
    if (emitted >= value_limit()) close_value(ST_FOUND);
  endtask

  // First non-blank byte after the colon decides what kind of value follows.
  task automatic open_value(input logic [7:0] b);
    emitted = '0;
    in_str  = 1'b0;
    esc     = 1'b0;
    depth   = '0;
    ph      = PH_VALUE;
    if (string_mode) begin
      if (b != CH_QUOTE) close_value(ST_NOT_STRING);
      else if (value_limit() == 0) close_value(ST_FOUND);
      else kind = KIND_STRING;
    end else if (value_limit() == 0) begin
      close_value(ST_FOUND);
    end else if (b == CH_QUOTE) begin
      kind = KIND_STRING;
      emit_value_byte(b);
    end else if (b == CH_LBRACE || b == CH_LBRACK) begin
      kind  = (b == CH_LBRACE) ? KIND_BRACE : KIND_BRACKET;
      depth = 1;
      emit_value_byte(b);
    end else begin
      kind = KIND_SCALAR;
      if (ends_scalar(b)) close_value(ST_FOUND);
      else emit_value_byte(b);
    end
  endtask

  task automatic extend_value(input logic [7:0] b);
    if (string_mode) begin
      // string contents only: drop the quotes and escape backslashes
      if (esc) begin
        esc = 1'b0;
        emit_value_byte(b);
      end else if (b == CH_BSLASH) begin
        esc = 1'b1;
      end else if (b == CH_QUOTE) begin
        close_value(ST_FOUND);
      end else begin
        emit_value_byte(b);
      end
    end else if (kind == KIND_SCALAR) begin
      if (ends_scalar(b)) close_value(ST_FOUND);
      else emit_value_byte(b);
    end else if (kind == KIND_STRING || in_str) begin
      emit_value_byte(b);
      if (esc) begin
        esc = 1'b0;
      end else if (b == CH_BSLASH) begin
        esc = 1'b1;
      end else if (b == CH_QUOTE) begin
        if (kind == KIND_STRING) begin
          if (ph == PH_VALUE) close_value(ST_FOUND);
        end else begin
          in_str = 1'b0;
        end
      end
    end else begin
      // group: count only brackets of its own kind, strings are skipped above
      emit_value_byte(b);
      if (b == CH_QUOTE) begin
        in_str = 1'b1;
      end else if (b == ((kind == KIND_BRACE) ? CH_LBRACE : CH_LBRACK)) begin
        if (depth != '1) depth++;
      end else if (b == ((kind == KIND_BRACE) ? CH_RBRACE : CH_RBRACK)) begin
        if (depth != 0) depth--;
        if (depth == 0 && ph == PH_VALUE) close_value(ST_FOUND);
      end
    end
  endtask

  // Advance the model by one accepted text byte and queue what it yields.
  task automatic track_text_byte(input logic [7:0] b, input logic eot);
    int i;
    if (eot || b == CH_NUL) begin
      case (ph)
        PH_SEARCH, PH_AFTER_KEY: close_value(ST_NOT_FOUND);
        PH_BEFORE_VALUE: begin
          emitted = '0;
          close_value(string_mode ? ST_NOT_STRING : ST_FOUND);
        end
        PH_VALUE: begin
          // a dangling backslash in string mode is passed on as itself
          if (string_mode && esc) emit_value_byte(CH_BSLASH);
          if (ph == PH_VALUE) close_value(ST_FOUND);
        end
        default: ;
      endcase
      rearm_model();
    end else begin
      for (i = WIN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      case (ph)
        PH_SEARCH: if (key_at_window()) ph = PH_AFTER_KEY;
        PH_AFTER_KEY: begin
          if (!is_blank(b)) begin
            if (b == CH_COLON) ph = PH_BEFORE_VALUE;
            else if (!key_at_window()) ph = PH_SEARCH;
          end
        end
        PH_BEFORE_VALUE: if (!is_blank(b)) open_value(b);
        PH_VALUE: extend_value(b);
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready with one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_pause) begin
      // hold off long enough for the buffer to fill and in_ready to drop
      out_ready <= 1'b0;
      repeat (RX_HOLD_CYCLES) @(negedge clk);
      sink_pause = 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= 10);
    end
  end

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Match every result transfer against the oldest one due.
  always @(posedge clk) begin : check_results
    item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none, actual byte %h last %b status %0d count %0d",
                 $time, out_byte, out_last, out_status, out_byte_count);
      end else begin
        want = results_due.pop_front();
        compare_field("out_byte", 16'(want.out_byte), 16'(out_byte));
        compare_field("out_last", 16'(want.last), 16'(out_last));
        compare_field("out_status", 16'(want.status), 16'(out_status));
        compare_field("out_byte_count", 16'(want.byte_count), 16'(out_byte_count));
      end
    end
  end

  // Drop the run if neither channel moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Text side; every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_text_byte(input logic [7:0] b, input logic eot);
    if (!no_gaps && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    track_text_byte(b, eot);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the text side until every result has arrived, then let it settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_reg(input reg_idx_t idx, input logic [63:0] value);
    case (idx)
      REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D: key_word[int'(idx)] = value;
      REG_KEY_LEN:  key_len     = value[KLEN_W-1:0];
      REG_CAPACITY: capacity    = value[CAP_W-1:0];
      REG_MODE:     string_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  logic [7:0] key_text [32];
  logic [7:0] text_buf [$];

  task automatic set_key_text(input string s);
    int i;
    for (i = 0; i < 32; i++) key_text[i] = (i < s.len()) ? s[i] : 8'h00;
  endtask

  // Write every register; only called with the block idle.
  task automatic configure(input int klen, input int cap, input bit mode);
    logic [63:0] word;
    int w;
    int j;
    settle();
    for (w = 0; w < KEY_WORDS; w++) begin
      for (j = 0; j < 8; j++) word[j*8 +: 8] = key_text[w*8 + j];
      write_reg(reg_idx_t'(w), word);
    end
    write_reg(REG_KEY_LEN, 64'(klen));
    write_reg(REG_CAPACITY, 64'(cap));
    write_reg(REG_MODE, 64'(mode));
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Send the buffered document, closed by a zero byte or by end_of_text.
  task automatic send_document(input bit zero_end);
    foreach (text_buf[i]) send_text_byte(text_buf[i], 1'b0);
    text_buf.delete();
    if (zero_end) send_text_byte(CH_NUL, 1'b0);
    else send_text_byte(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(99) < 8) return 8'($urandom_range(128, 255));
    do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic add_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(3))
        0: text_buf.push_back(CH_SPACE);
        1: text_buf.push_back(CH_TAB);
        2: text_buf.push_back(CH_LF);
        default: text_buf.push_back(CH_CR);
      endcase
    end
  endtask

  task automatic add_string_value();
    text_buf.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(99) < 15) begin
        text_buf.push_back(CH_BSLASH);
        text_buf.push_back(8'($urandom_range(32, 126)));
      end else begin
        text_buf.push_back(plain_char());
      end
    end
    // leave some strings open so the end of text cuts them
    if ($urandom_range(9) != 0) text_buf.push_back(CH_QUOTE);
  endtask

  task automatic add_scalar();
    string glyphs = "0123456789-+.eEtrufalsn";
    repeat ($urandom_range(1, 5)) text_buf.push_back(glyphs[$urandom_range(glyphs.len() - 1)]);
  endtask

  task automatic add_group(input int level);
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    int n;
    int e;
    if ($urandom_range(1)) begin
      open_ch  = CH_LBRACE;
      close_ch = CH_RBRACE;
    end else begin
      open_ch  = CH_LBRACK;
      close_ch = CH_RBRACK;
    end
    text_buf.push_back(open_ch);
    n = $urandom_range(0, 3);
    for (e = 0; e < n; e++) begin
      if (e > 0) text_buf.push_back(CH_COMMA);
      add_blanks();
      case ($urandom_range(4))
        0: add_string_value();
        1: add_scalar();
        2: if (level < 2) add_group(level + 1); else add_scalar();
        3: begin
          add_string_value();
          text_buf.push_back(CH_COLON);
          add_scalar();
        end
        default: begin
          // stray bracket, counted only when it matches the group's kind
          case ($urandom_range(3))
            0: text_buf.push_back(CH_LBRACE);
            1: text_buf.push_back(CH_RBRACE);
            2: text_buf.push_back(CH_LBRACK);
            default: text_buf.push_back(CH_RBRACK);
          endcase
        end
      endcase
    end
    if ($urandom_range(9) != 0) text_buf.push_back(close_ch);
  endtask

  task automatic add_value();
    case ($urandom_range(9))
      0, 1, 2, 3: add_string_value();
      4, 5, 6: add_group(0);
      7, 8: begin
        add_scalar();
        if ($urandom_range(1)) text_buf.push_back($urandom_range(1) ? CH_COMMA : CH_RBRACE);
      end
      default: ;   // nothing: the text ends right after the colon
    endcase
  endtask

  // Quoted key as programmed, now and then with one character spoilt.
  task automatic add_key_occurrence();
    int n;
    int bad;
    int i;
    n   = (key_len > 32) ? 32 : int'(key_len);
    bad = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : -1;
    text_buf.push_back(CH_QUOTE);
    for (i = 0; i < n; i++) text_buf.push_back((i == bad) ? plain_char() : key_text[i]);
    text_buf.push_back(CH_QUOTE);
  endtask

  task automatic build_document();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      // noise: any non-zero byte
      repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(3) == 0) add_text("{\"a\":1,");
      if ($urandom_range(4) == 0) begin
        add_key_occurrence();
        text_buf.push_back(CH_COMMA);
      end
      add_key_occurrence();
      add_blanks();
      if ($urandom_range(9) != 0) text_buf.push_back(CH_COLON);
      add_blanks();
      add_value();
      if ($urandom_range(2) == 0) add_text(",\"z\":0}");
    end
  endtask

  task automatic run_documents(input int budget);
    int stop;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      build_document();
      send_document($urandom_range(3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: empty key matches a bare pair of quotes, capacity 64, raw.
  task automatic test_reset_values();
    add_text("\"\":");
    send_document(1'b1);
    add_text("xy");
    send_document(1'b0);
  endtask

  // Raw copies of each value kind, a missing key and an empty value.
  task automatic test_raw_values();
    set_key_text("k");
    configure(1, 64, 1'b0);
    add_text("\"k\" :{\"s\":\"}\\\"\",[1]}");
    send_document(1'b0);
    add_text("\"k\":[[1],2]");
    send_document(1'b1);
    add_text("\"k\":\t-7,");
    send_document(1'b0);
    add_text("\"k\":\"a\\\"b\"");
    send_document(1'b0);
    add_text("\"q\":1");
    send_document(1'b0);
    add_text("\"k\"\t");
    send_document(1'b1);
    add_text("\"k\":");
    send_document(1'b0);
  endtask

  // String mode: unescape, reject non-strings, keep a trailing backslash.
  task automatic test_string_values();
    configure(1, 64, 1'b1);
    add_text("\"k\": \"a\\\"b\"");
    send_document(1'b0);
    add_text("\"k\":7");
    send_document(1'b0);
    add_text("\"k\":\"ab\\");
    send_document(1'b0);
    add_text("\"k\":");
    send_document(1'b1);
  endtask

  // Byte limit: truncation, then capacity zero and one.
  task automatic test_byte_limits();
    configure(1, 3, 1'b0);
    add_text("\"k\":\"abcd\"");
    send_document(1'b0);
    configure(1, 0, 1'b0);
    add_text("\"k\":1");
    send_document(1'b0);
    configure(1, 1, 1'b1);
    add_text("\"k\":\"x\"");
    send_document(1'b1);
  endtask

  // Overlapping occurrences: the first is not followed by a colon, the second is.
  task automatic test_overlapping_key();
    set_key_text("x\"x");
    configure(3, 64, 1'b0);
    add_text("\"x\"x\"x\":1}");
    send_document(1'b0);
  endtask

  // Stall the receiver while a long value streams in, so in_ready must drop.
  task automatic test_backpressure();
    set_key_text("k");
    configure(1, 65535, 1'b0);
    sink_pause = 1'b1;
    add_text("\"k\":\"");
    repeat (80) text_buf.push_back(8'($urandom_range(97, 122)));
    text_buf.push_back(CH_QUOTE);
    send_document(1'b0);
    settle();
  endtask

  // Random documents under a range of register settings.
  task automatic test_random_documents();
    int i;
    set_key_text("name");
    configure(4, 64, 1'b0);
    run_documents(100);
    configure(4, 64, 1'b1);
    run_documents(100);
    for (i = 0; i < 32; i++) key_text[i] = 8'($urandom_range(1, 255));
    configure(32, 65535, 1'b0);
    run_documents(80);
    set_key_text("a");
    configure(1, 2, 1'b1);
    run_documents(80);
    configure(0, 0, 1'b0);
    run_documents(65);
    // keys longer than the window never match
    for (i = 0; i < 32; i++) key_text[i] = 8'($urandom_range(97, 122));
    configure(33, 1, 1'b0);
    run_documents(40);
    configure(63, 64, 1'b1);
    run_documents(40);
    // back to back on both sides
    set_key_text("k2");
    no_gaps = 1'b1;
    configure(2, 5, 1'b0);
    run_documents(100);
    no_gaps = 1'b0;
    set_key_text("id");
    configure(2, 3, 1'b1);
    run_documents(75);
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_raw_values();
    test_string_values();
    test_byte_limits();
    test_overlapping_key();
    test_backpressure();
    test_random_documents();

    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/jkve_pkg.sv
hdl/jkve_cell.sv
hdl/jkve_out_fifo.sv
hdl/json_key_value_extractor.sv
tb/testbench.sv
